// ===== src/uv_sphere_vertex_and_triangles_top_macros.svh =====
// Assertion macros shared by the sphere tessellation RTL.
`ifndef UV_SPHERE_VERTEX_AND_TRIANGLES_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_AND_TRIANGLES_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define UVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/uvs_pkg.sv =====
// Shared types and constants of the sphere tessellation block.
package uvs_pkg;

  localparam int DEF_MAX_SEGMENTS    = 64;
  localparam int DEF_COORD_FRAC_BITS = 14;

  localparam int IDX_W   = 13;
  localparam int COORD_W = 16;
  localparam int GRID_W  = 7;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_BAND   = 2'd2;

  localparam logic [6:0] RST_HEIGHT = 7'd8;
  localparam logic [6:0] RST_WIDTH  = 7'd6;
  localparam logic [7:0] RST_BAND   = 8'd1;

  // Odd sine polynomial coefficients in Q30, power 1 first.
  localparam logic [30:0] SIN_C [6] = '{
    31'd1686629713, 31'd693598668, 31'd85569305,
    31'd5026995, 31'd172272, 31'd3864
  };

  typedef struct packed {
    logic [GRID_W-1:0] row;
    logic [GRID_W-1:0] col;
    logic              oor;
    logic              upper;
    logic              lower;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  ridx;
    logic [IDX_W-1:0]  bidx;
    logic [IDX_W-1:0]  bridx;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               upper;
    logic               lower;
    logic [IDX_W-1:0]   ridx;
    logic [IDX_W-1:0]   bidx;
    logic [IDX_W-1:0]   bridx;
    logic               oor;
  } res_t;

endpackage

// ===== src/uv_sphere_vertex_and_triangles_top.sv =====
// Top level of the UV sphere vertex and triangle generator.
//
//  port group    | dir | contents
//  s_t*          | in  | grid point: row, column
//  m_t*          | out | vertex index, position, quad indices, triangle flags
//  wr_*          | in  | register writes: 0 height, 1 width, 2 zero band
//
// One item per cycle is accepted while the queue is not full, and one result per cycle
// is delivered while the output is not stalled. Items pass through the 34-step phase
// dividers (six stages) and the sine pipeline.
// The queue between front and back holds four items; s_tready drops only when it is full.
// A stalled output freezes the whole back pipeline. Reset flushes it and restores registers.
`include "uv_sphere_vertex_and_triangles_top_macros.svh"
module uv_sphere_vertex_and_triangles_top import uvs_pkg::*; #(
  parameter int MAX_SEGMENTS    = DEF_MAX_SEGMENTS,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // grid_row[6:0], grid_col[13:7]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // vertex_index, pos_x, pos_y, pos_z, upper_tri_valid,
                                  // lower_tri_valid, right_index, below_index,
                                  // below_right_index
  output logic [0:0]   m_tuser,   // out_of_range
  input  logic         wr_en,
  input  logic [1:0]   wr_index,
  input  logic [7:0]   wr_data
);

  localparam int HW = $clog2(MAX_SEGMENTS + 1);

  logic [6:0]    reg_h;
  logic [6:0]    reg_w;
  logic [7:0]    reg_band;
  logic [HW-1:0] h;
  logic [HW-1:0] w;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_h    <= RST_HEIGHT;
      reg_w    <= RST_WIDTH;
      reg_band <= RST_BAND;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HEIGHT: reg_h    <= wr_data[6:0];
        REG_WIDTH:  reg_w    <= wr_data[6:0];
        REG_BAND:   reg_band <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (reg_h < 7'd2) h = HW'(2);
    else if (32'(reg_h) > MAX_SEGMENTS) h = HW'(MAX_SEGMENTS);
    else h = HW'(reg_h);
    if (reg_w < 7'd3) w = HW'(3);
    else if (32'(reg_w) > MAX_SEGMENTS) w = HW'(MAX_SEGMENTS);
    else w = HW'(reg_w);
  end

  item_t f_item;
  item_t q_item;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  res_t  res;

  uvs_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .row  (s_tdata[6:0]),
    .col  (s_tdata[13:7]),
    .h    (h),
    .w    (w),
    .item (f_item)
  );

  assign s_tready = !q_full;

  uvs_fifo #(.DEPTH(4)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (s_tvalid && !q_full),
    .wdata (f_item),
    .pop   (q_pop),
    .rdata (q_item),
    .full  (q_full),
    .empty (q_empty)
  );

  uvs_back #(
    .MAX_SEGMENTS    (MAX_SEGMENTS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .h         (h),
    .w         (w),
    .band      (reg_band),
    .in_valid  (!q_empty),
    .in_item   (q_item),
    .in_pop    (q_pop),
    .out_valid (m_tvalid),
    .out_res   (res),
    .out_ready (m_tready)
  );

  assign m_tdata = {2'b00, res.bridx, res.bidx, res.ridx, res.lower, res.upper,
                    res.z, res.y, res.x, res.idx};
  assign m_tuser = res.oor;

  `UVS_ASSERT_NOW(a_oor_zero, m_tvalid && m_tuser[0], m_tdata == '0, "out of range item not zeroed")
  `UVS_ASSERT_NOW(a_oor_no_tri, m_tvalid && m_tuser[0], !m_tdata[61] && !m_tdata[62], "out of range item flags a triangle")
  `UVS_ASSERT_NOW(a_right_idx, m_tvalid && (m_tdata[61] || m_tdata[62]), m_tdata[75:63] == m_tdata[12:0] + 13'd1, "right index does not follow vertex index")
  `UVS_ASSERT_NEXT(a_queue_full, s_tvalid && s_tready && q_full == 1'b0 && !q_pop && !q_empty && s_tready, !q_empty, "queue lost an item")

endmodule

// ===== src/uvs_front.sv =====
// Front part: range check, quad flags and vertex indices of one grid point.
module uvs_front import uvs_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  localparam int HW = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic [GRID_W-1:0] row,
  input  logic [GRID_W-1:0] col,
  input  logic [HW-1:0]     h,
  input  logic [HW-1:0]     w,
  output item_t             item
);

  logic        oor;
  logic        quad;
  logic [31:0] wp1;
  logic [31:0] base;
  logic [31:0] below;

  always_comb begin
    oor   = (32'(row) > 32'(h)) || (32'(col) > 32'(w));
    quad  = (32'(row) < 32'(h)) && (32'(col) < 32'(w));
    wp1   = 32'(w) + 32'd1;
    base  = 32'(row) * wp1 + 32'(col);
    below = base + wp1;
    item       = '0;
    item.row   = row;
    item.col   = col;
    item.oor   = oor;
    if (!oor) begin
      item.idx = IDX_W'(base);
      if (quad) begin
        item.upper = (row != '0);
        item.lower = (32'(row) != 32'(h) - 32'd1);
        item.ridx  = IDX_W'(base + 32'd1);
        item.bidx  = IDX_W'(below);
        item.bridx = IDX_W'(below + 32'd1);
      end
    end
  end

endmodule

// ===== src/uvs_fifo.sv =====
// Short register queue between the front and back parts.
module uvs_fifo import uvs_pkg::*; #(
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  input  logic  pop,
  output item_t rdata,
  output logic  full,
  output logic  empty
);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== src/uvs_back.sv =====
// Back part: phase dividers, sine pipelines and coordinate rounding.
module uvs_back import uvs_pkg::*; #(
  parameter int MAX_SEGMENTS    = DEF_MAX_SEGMENTS,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  localparam int HW = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [HW-1:0] h,
  input  logic [HW-1:0] w,
  input  logic [7:0]    band,
  input  logic          in_valid,
  input  item_t         in_item,
  output logic          in_pop,
  output logic          out_valid,
  output res_t          out_res,
  input  logic          out_ready
);

  localparam int RW      = $clog2(4 * MAX_SEGMENTS);
  localparam int QW      = 34;
  localparam int DIV_PER = 6;
  localparam int ND      = (QW + DIV_PER - 1) / DIV_PER;
  localparam int SH      = 60 - COORD_FRAC_BITS;

  logic adv;
  assign adv    = !out_valid || out_ready;
  assign in_pop = adv && in_valid;

  // One quotient bit per step: compare, subtract, double the remainder.
  function automatic logic [RW+QW-1:0] div_run(input logic [RW-1:0] r_in,
                                               input logic [QW-1:0] q_in,
                                               input logic [RW-1:0] d,
                                               input int n);
    logic [RW-1:0] r;
    logic [QW-1:0] q;
    r = r_in;
    q = q_in;
    for (int k = 0; k < DIV_PER; k++) begin
      if (k < n) begin
        if (r >= d) begin
          r = r - d;
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
        r = {r[RW-2:0], 1'b0};
      end
    end
    return {r, q};
  endfunction

  function automatic logic [15:0] to_coord(input logic [60:0] mag, input logic neg,
                                           input logic [7:0] bnd);
    logic [61:0] sum;
    logic [61:0] sh;
    logic [14:0] r;
    sum = 62'(mag) + (62'd1 << (SH - 1));
    sh  = sum >> SH;
    r   = (sh > 62'd32767) ? 15'd32767 : sh[14:0];
    if (r <= 15'(bnd)) begin
      return '0;
    end
    return neg ? 16'(-{1'b0, r}) : {1'b0, r};
  endfunction

  logic [RW-1:0] den_t;
  logic [RW-1:0] den_p;
  assign den_t = RW'({h, 1'b0});
  assign den_p = RW'(w);

  // Divider stages.
  logic          v_d  [ND];
  item_t         it_d [ND];
  logic [RW-1:0] rt_d [ND];
  logic [RW-1:0] rp_d [ND];
  logic [QW-1:0] qt_d [ND];
  logic [QW-1:0] qp_d [ND];

  for (genvar s = 0; s < ND; s++) begin : g_div
    localparam int N = (QW - s * DIV_PER < DIV_PER) ? QW - s * DIV_PER : DIV_PER;
    logic [RW-1:0] rt_in;
    logic [RW-1:0] rp_in;
    logic [QW-1:0] qt_in;
    logic [QW-1:0] qp_in;
    if (s == 0) begin : g_first
      assign rt_in = RW'(in_item.row);
      assign rp_in = RW'(in_item.col);
      assign qt_in = '0;
      assign qp_in = '0;
    end else begin : g_next
      assign rt_in = rt_d[s-1];
      assign rp_in = rp_d[s-1];
      assign qt_in = qt_d[s-1];
      assign qp_in = qp_d[s-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_d[s] <= 1'b0;
      end else if (adv) begin
        v_d[s] <= (s == 0) ? in_valid : v_d[s > 0 ? s - 1 : 0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        it_d[s]              <= (s == 0) ? in_item : it_d[s > 0 ? s - 1 : 0];
        {rt_d[s], qt_d[s]}   <= div_run(rt_in, qt_in, den_t, N);
        {rp_d[s], qp_d[s]}   <= div_run(rp_in, qp_in, den_p, N);
      end
    end
  end

  // Lanes: 0 sin theta, 1 cos theta, 2 sin phi, 3 cos phi.
  logic [31:0] ph_t;
  logic [31:0] ph_p;
  logic [31:0] ph [4];
  assign ph_t  = 32'((qt_d[ND-1] + QW'(1)) >> 1);
  assign ph_p  = 32'((qp_d[ND-1] + QW'(1)) >> 1);
  assign ph[0] = ph_t;
  assign ph[1] = ph_t + 32'h4000_0000;
  assign ph[2] = ph_p;
  assign ph[3] = ph_p + 32'h4000_0000;

  logic        v_a, v_b, v_f, v_m;
  item_t       it_a, it_b, it_f, it_m;
  logic [30:0] t_a  [4];
  logic        qn_a [4];
  logic [30:0] t_b  [4];
  logic [30:0] t2_b [4];
  logic        qn_b [4];
  logic        v_h  [5];
  item_t       it_h [5];
  logic [30:0] t_h  [5][4];
  logic [30:0] t2_h [5][4];
  logic [30:0] p_h  [5][4];
  logic        qn_h [5][4];
  logic [30:0] m_f  [4];
  logic        n_f  [4];
  logic [60:0] px, py, pz;
  logic        nx, ny, nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_f <= 1'b0;
      v_m <= 1'b0;
      for (int s = 0; s < 5; s++) v_h[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_a <= v_d[ND-1];
      v_b <= v_a;
      v_h[0] <= v_b;
      for (int s = 1; s < 5; s++) v_h[s] <= v_h[s-1];
      v_f <= v_h[4];
      v_m <= v_f;
      out_valid <= v_m;
    end
  end

  logic [61:0] prod_sq [4];
  logic [61:0] prod_h  [5][4];
  logic [61:0] prod_f  [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      prod_sq[l] = 62'(t_a[l]) * 62'(t_a[l]);
      prod_f[l]  = 62'(t_h[4][l]) * 62'(p_h[4][l]);
      prod_h[0][l] = 62'(t2_b[l]) * 62'(SIN_C[5]);
      for (int s = 1; s < 5; s++) prod_h[s][l] = 62'(t2_h[s-1][l]) * 62'(p_h[s-1][l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_a <= it_d[ND-1];
      for (int l = 0; l < 4; l++) begin
        t_a[l]  <= ph[l][30] ? 31'h4000_0000 - 31'(ph[l][29:0]) : 31'(ph[l][29:0]);
        qn_a[l] <= ph[l][31];
      end
      it_b <= it_a;
      for (int l = 0; l < 4; l++) begin
        t_b[l]  <= t_a[l];
        t2_b[l] <= 31'(prod_sq[l] >> 30);
        qn_b[l] <= qn_a[l];
      end
      it_h[0] <= it_b;
      for (int l = 0; l < 4; l++) begin
        t_h[0][l]  <= t_b[l];
        t2_h[0][l] <= t2_b[l];
        qn_h[0][l] <= qn_b[l];
        p_h[0][l]  <= SIN_C[4] - 31'(prod_h[0][l] >> 30);
      end
      for (int s = 1; s < 5; s++) begin
        it_h[s] <= it_h[s-1];
        for (int l = 0; l < 4; l++) begin
          t_h[s][l]  <= t_h[s-1][l];
          t2_h[s][l] <= t2_h[s-1][l];
          qn_h[s][l] <= qn_h[s-1][l];
          p_h[s][l]  <= SIN_C[4-s] - 31'(prod_h[s][l] >> 30);
        end
      end
      it_f <= it_h[4];
      for (int l = 0; l < 4; l++) begin
        if ((prod_f[l] >> 30) > 62'h4000_0000) begin
          m_f[l] <= 31'h4000_0000;
          n_f[l] <= qn_h[4][l];
        end else begin
          m_f[l] <= 31'(prod_f[l] >> 30);
          n_f[l] <= qn_h[4][l] && ((prod_f[l] >> 30) != '0);
        end
      end
      it_m <= it_f;
      px <= 61'(m_f[3]) * 61'(m_f[0]);
      pz <= 61'(m_f[2]) * 61'(m_f[0]);
      py <= 61'(m_f[1]) << 30;
      nx <= (n_f[3] == n_f[0]);
      nz <= (n_f[2] != n_f[0]);
      ny <= n_f[1];
      out_res.oor   <= it_m.oor;
      out_res.idx   <= it_m.idx;
      out_res.upper <= it_m.upper;
      out_res.lower <= it_m.lower;
      out_res.ridx  <= it_m.ridx;
      out_res.bidx  <= it_m.bidx;
      out_res.bridx <= it_m.bridx;
      out_res.x     <= it_m.oor ? '0 : to_coord(px, nx, band);
      out_res.y     <= it_m.oor ? '0 : to_coord(py, ny, band);
      out_res.z     <= it_m.oor ? '0 : to_coord(pz, nz, band);
    end
  end

endmodule
